### rtl/core/aes_pkg.sv
// Shared types, constants, and round functions for the AES block encryptor.
package aes_pkg;

  localparam int KEY_WORDS   = 4;
  localparam int ROUNDS      = 10;
  localparam int STORE_WORDS = 4 * (ROUNDS + 1);
  localparam int IDX_W       = $clog2(STORE_WORDS);
  localparam int ROW_W       = $clog2(ROUNDS + 1);
  localparam int KW_CNT_W    = 3;
  localparam int CFG_IDX_W   = 2;

  // Position inside a key-word group where 256-bit keys take an extra SubWord.
  localparam logic [KW_CNT_W-1:0] KW_SUB_POS = 3'd4;
  localparam logic [7:0]          RCON_INIT  = 8'h01;
  localparam logic [7:0]          GF_POLY    = 8'h1b;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0 = 2'd0,
    CFG_KEY_1 = 2'd1,
    CFG_KEY_2 = 2'd2,
    CFG_KEY_3 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] plain_first;
    logic [63:0] plain_second;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_first;
    logic [63:0] cipher_second;
  } aes_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte k of the state sits in bits 127-8k down to 120-8k; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = r + 4 * ((c + r) % 4);
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

### rtl/core/aes_block_encrypt.sv
// AES forward cipher: key schedule sequencer, iterative round unit, and result register.
// The result is registered after ROUNDS + 1 passes through the single round unit, one pass
// per round; a new block is taken only once the previous result is registered.
// A full round key row is read from the schedule memory each cycle, one row per round.
// After reset and after every key write the schedule is rebuilt one word per cycle, and the
// input stalls until the rebuild is done. Reset zeroes the key registers.
module aes_block_encrypt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  aes_pkg::aes_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output aes_pkg::aes_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXPAND = 3'b010,
    S_RUN    = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           key_dirty_r, key_dirty_nxt;
  logic [aes_pkg::ROW_W-1:0]      round_r, round_nxt;
  logic [aes_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [aes_pkg::KW_CNT_W-1:0]   kmod_r, kmod_nxt;
  logic [7:0]                     rcon_r, rcon_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [63:0]                    key_0_r, key_1_r, key_2_r, key_3_r;

  logic [31:0]                    win_r [aes_pkg::KEY_WORDS];
  logic [95:0]                    row_buf_r;
  logic [127:0]                   rk_r;
  logic [127:0]                   data_r;
  aes_pkg::aes_out_t              out_data_r;
  logic [127:0]                   sched_mem [aes_pkg::ROUNDS + 1];

  logic                           accept;
  logic                           out_free;
  logic                           last_round;
  logic                           finish;
  logic                           win_load;
  logic                           mem_we;
  logic [aes_pkg::ROW_W-1:0]      rd_addr;
  logic [31:0]                    t_word;
  logic [31:0]                    new_word;
  logic [255:0]                   key_words;
  logic [127:0]                   round_out;
  logic [127:0]                   shifted;

  assign in_stall   = !((state_r == S_IDLE) && !key_dirty_r);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_round = (round_r == aes_pkg::ROW_W'(aes_pkg::ROUNDS));
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign key_words  = {key_0_r, key_1_r, key_2_r, key_3_r};
  assign mem_we     = (state_r == S_EXPAND) && (idx_r[1:0] == 2'b11);

  // Next schedule word from the sliding window of the last KEY_WORDS words.
  always_comb begin
    t_word = win_r[aes_pkg::KEY_WORDS-1];
    if (idx_r >= aes_pkg::IDX_W'(aes_pkg::KEY_WORDS)) begin
      if (kmod_r == '0) begin
        t_word = aes_pkg::sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_r, 24'h000000};
      end else if ((aes_pkg::KEY_WORDS > 6) && (kmod_r == aes_pkg::KW_SUB_POS)) begin
        t_word = aes_pkg::sub_word(t_word);
      end
      new_word = win_r[0] ^ t_word;
    end else begin
      // The first KEY_WORDS words are the key itself, rotated out of the window.
      new_word = win_r[0];
    end
  end

  // Shared round unit: key add alone in pass zero, no MixColumns in the last pass.
  always_comb begin
    shifted = aes_pkg::sub_shift(data_r);
    if (round_r == '0) begin
      round_out = data_r ^ rk_r;
    end else if (last_round) begin
      round_out = shifted ^ rk_r;
    end else begin
      round_out = aes_pkg::mix_columns(shifted) ^ rk_r;
    end
  end

  always_comb begin
    if ((state_r == S_RUN) && !last_round) begin
      rd_addr = round_r + 1'b1;
    end else if (state_r == S_RUN) begin
      rd_addr = round_r;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key_dirty_nxt = key_dirty_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    kmod_nxt      = kmod_r;
    rcon_nxt      = rcon_r;
    out_valid_nxt = out_valid_r && out_stall;
    finish        = 1'b0;
    win_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (key_dirty_r) begin
          state_nxt     = S_EXPAND;
          key_dirty_nxt = 1'b0;
          idx_nxt       = '0;
          kmod_nxt      = '0;
          rcon_nxt      = aes_pkg::RCON_INIT;
          win_load      = 1'b1;
        end else if (accept) begin
          state_nxt = S_RUN;
          round_nxt = '0;
        end
      end
      S_EXPAND: begin
        idx_nxt = idx_r + 1'b1;
        if (kmod_r == aes_pkg::KW_CNT_W'(aes_pkg::KEY_WORDS - 1)) begin
          kmod_nxt = '0;
        end else begin
          kmod_nxt = kmod_r + 1'b1;
        end
        if ((idx_r >= aes_pkg::IDX_W'(aes_pkg::KEY_WORDS)) && (kmod_r == '0)) begin
          rcon_nxt = aes_pkg::xtime(rcon_r);
        end
        if (idx_r == aes_pkg::IDX_W'(aes_pkg::STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        if (!last_round) begin
          round_nxt = round_r + 1'b1;
        end else if (out_free) begin
          finish        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // A key write always forces a fresh schedule, even one landing mid-expansion.
    if (cfg_we) begin
      key_dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_dirty_r <= 1'b1;
      round_r     <= '0;
      idx_r       <= '0;
      kmod_r      <= '0;
      rcon_r      <= aes_pkg::RCON_INIT;
      out_valid_r <= 1'b0;
      key_0_r     <= '0;
      key_1_r     <= '0;
      key_2_r     <= '0;
      key_3_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      key_dirty_r <= key_dirty_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      kmod_r      <= kmod_nxt;
      rcon_r      <= rcon_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (aes_pkg::cfg_idx_t'(cfg_index))
          aes_pkg::CFG_KEY_0: key_0_r <= cfg_data;
          aes_pkg::CFG_KEY_1: key_1_r <= cfg_data;
          aes_pkg::CFG_KEY_2: key_2_r <= cfg_data;
          aes_pkg::CFG_KEY_3: key_3_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_load) begin
      for (int j = 0; j < aes_pkg::KEY_WORDS; j++) begin
        win_r[j] <= key_words[255 - 32 * j -: 32];
      end
    end else if (state_r == S_EXPAND) begin
      for (int j = 0; j < aes_pkg::KEY_WORDS - 1; j++) begin
        win_r[j] <= win_r[j + 1];
      end
      win_r[aes_pkg::KEY_WORDS-1] <= new_word;
    end
    if (state_r == S_EXPAND) begin
      row_buf_r <= {row_buf_r[63:0], new_word};
    end
    if (accept) begin
      data_r <= in_data;
    end else if ((state_r == S_RUN) && !last_round) begin
      data_r <= round_out;
    end
    if (finish) begin
      out_data_r <= round_out;
    end
  end

  // Round key memory: one 128-bit row per round, written every fourth schedule word.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sched_mem[idx_r[aes_pkg::IDX_W-1:2]] <= {row_buf_r, new_word};
    end
    rk_r <= sched_mem[rd_addr];
  end

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (round_r <= aes_pkg::ROW_W'(aes_pkg::ROUNDS)))
    else $error("round counter past the last round");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past((state_r == S_RUN) && last_round))
    else $error("result beat raised outside the final round");

  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RUN) && $past(state_r == S_IDLE)) |-> $past(!key_dirty_r))
    else $error("block started on a stale key schedule");

  a_expand_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && $past(state_r == S_EXPAND))
      |-> ($past(idx_r) == aes_pkg::IDX_W'(aes_pkg::STORE_WORDS - 1)))
    else $error("key expansion ended early");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !mem_we)
    else $error("schedule memory written during encryption");

endmodule

### verif/aes_block_encrypt_test.sv
// Self-checking testbench for the AES block encryptor: directed vectors, then random blocks.
module aes_block_encrypt_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  HALF_PERIOD  = 4;
  localparam int  RESET_CYCLES = 5;
  localparam int  PHASES       = 8;
  localparam int  PHASE_BLOCKS = 105;
  localparam int  HOLD_CYCLES  = 200;
  localparam int  DRAIN_CYCLES = 4 * (aes_pkg::ROUNDS + 2);
  localparam longint TIMEOUT_NS = 3_000_000;

  localparam logic [7:0] REDUCE_POLY  = 8'h1b;
  localparam logic [7:0] AFFINE_CONST = 8'h63;
  localparam logic [7:0] RCON_FIRST   = 8'h01;

  // Known-answer vectors below hold only for the 128-bit key build.
  localparam bit KAT_BUILD = (aes_pkg::KEY_WORDS == 4) && (aes_pkg::ROUNDS == 10);

  localparam logic [255:0] KEY_ZERO  = '0;
  localparam logic [255:0] KEY_ONES  = '1;
  localparam logic [255:0] KEY_SEQ   =
    256'h000102030405060708090a0b0c0d0e0f_101112131415161718191a1b1c1d1e1f;
  localparam logic [255:0] KEY_FIPS  = {128'h2b7e151628aed2a6abf7158809cf4f3c, 128'h0};
  localparam logic [255:0] KEY_UPPER = {128'h0, {128{1'b1}}};
  localparam logic [255:0] KEY_EDGE  = {1'b1, 254'h0, 1'b1};

  localparam logic [127:0] CT_ZERO_KEY = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;

  typedef struct packed {
    logic [255:0]      key;
    aes_pkg::aes_in_t  plain;
    logic              known;
    aes_pkg::aes_out_t cipher;
  } directed_vec_t;

  localparam int DIRECTED_ROWS = 14;
  localparam directed_vec_t DIRECTED [DIRECTED_ROWS] = '{
    '{KEY_ZERO,  128'h0,                                1'b1, CT_ZERO_KEY},
    '{KEY_ZERO,  {128{1'b1}},                           1'b0, 128'h0},
    '{KEY_ZERO,  {1'b1, 127'h0},                        1'b0, 128'h0},
    '{KEY_ZERO,  128'h1,                                1'b0, 128'h0},
    '{KEY_ZERO,  {16{8'haa}},                           1'b0, 128'h0},
    '{KEY_ZERO,  {16{8'h55}},                           1'b0, 128'h0},
    '{KEY_SEQ,   128'h00112233445566778899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{KEY_SEQ,   128'h0,                                1'b0, 128'h0},
    '{KEY_FIPS,  128'h3243f6a8885a308d313198a2e0370734, 1'b1,
      128'h3925841d02dc09fbdc118597196a0b32},
    '{KEY_ONES,  128'h0,                                1'b0, 128'h0},
    '{KEY_ONES,  {128{1'b1}},                           1'b0, 128'h0},
    // Only the words past the key length are set, so the zero-key answer must come back.
    '{KEY_UPPER, 128'h0,                                1'b1, CT_ZERO_KEY},
    '{KEY_EDGE,  {128{1'b1}},                           1'b0, 128'h0},
    '{KEY_EDGE,  128'h0,                                1'b0, 128'h0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  aes_pkg::aes_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  aes_pkg::aes_out_t out_data;
  logic              cfg_we;
  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]       cfg_data;

  aes_block_encrypt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Predictor state: key registers, expanded schedule and the substitution table.
  logic [7:0]  sub_tbl [256];
  logic [63:0] key_reg [4];
  logic [31:0] sched [aes_pkg::STORE_WORDS];
  logic [255:0] loaded_key;

  aes_pkg::aes_out_t pending_ciphers [$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  bit       hold_req = 1'b0;
  bit       hold_off = 1'b0;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  // S-box from the field inverse (x^254) followed by the affine map.
  function automatic void build_sub_table();
    logic [7:0] p, inv;
    for (int v = 0; v < 256; v++) begin
      p = v[7:0];
      inv = 8'h01;
      for (int k = 0; k < 7; k++) begin
        p = gf_mul(p, p);
        inv = gf_mul(inv, p);
      end
      if (v == 0) inv = 8'h00;
      sub_tbl[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                   {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
    end
  endfunction

  function automatic logic [31:0] substitute_word(input logic [31:0] w);
    return {sub_tbl[w[31:24]], sub_tbl[w[23:16]], sub_tbl[w[15:8]], sub_tbl[w[7:0]]};
  endfunction

  function automatic void rebuild_schedule();
    logic [31:0] kw [8];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = RCON_FIRST;
    for (int j = 0; j < 4; j++) begin
      kw[2 * j]     = key_reg[j][63:32];
      kw[2 * j + 1] = key_reg[j][31:0];
    end
    for (int i = 0; i < aes_pkg::KEY_WORDS; i++) sched[i] = kw[i];
    for (int i = aes_pkg::KEY_WORDS; i < aes_pkg::STORE_WORDS; i++) begin
      t = sched[i - 1];
      if (i % aes_pkg::KEY_WORDS == 0) begin
        t = substitute_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_double(rc);
      end else if (aes_pkg::KEY_WORDS > 6 && i % aes_pkg::KEY_WORDS == 4) begin
        t = substitute_word(t);
      end
      sched[i] = sched[i - aes_pkg::KEY_WORDS] ^ t;
    end
  endfunction

  function automatic logic [127:0] round_key(input int r);
    return {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
  endfunction

  // Byte i of the state sits at bits 127-8i; row r of column c is byte r+4c.
  function automatic logic [127:0] shift_substitute(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sub_tbl[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   b0, b1, b2, b3, sum;
    for (int c = 0; c < 4; c++) begin
      b0  = s[127 - 32 * c -: 8];
      b1  = s[119 - 32 * c -: 8];
      b2  = s[111 - 32 * c -: 8];
      b3  = s[103 - 32 * c -: 8];
      sum = b0 ^ b1 ^ b2 ^ b3;
      t[127 - 32 * c -: 8] = b0 ^ sum ^ gf_double(b0 ^ b1);
      t[119 - 32 * c -: 8] = b1 ^ sum ^ gf_double(b1 ^ b2);
      t[111 - 32 * c -: 8] = b2 ^ sum ^ gf_double(b2 ^ b3);
      t[103 - 32 * c -: 8] = b3 ^ sum ^ gf_double(b3 ^ b0);
    end
    return t;
  endfunction

  function automatic aes_pkg::aes_out_t encrypt_block(input aes_pkg::aes_in_t blk);
    logic [127:0] st;
    st = blk ^ round_key(0);
    for (int r = 1; r < aes_pkg::ROUNDS; r++) st = mix_state(shift_substitute(st)) ^ round_key(r);
    st = shift_substitute(st) ^ round_key(aes_pkg::ROUNDS);
    return st;
  endfunction

  function automatic aes_pkg::aes_in_t random_block();
    logic [127:0] v;
    v = '0;
    case ($urandom_range(0, 7))
      0: v = 128'h1 << $urandom_range(0, 127);
      1: for (int j = 0; j < 16; j++) v = {v[119:0], ($urandom_range(0, 1) ? 8'hff : 8'h00)};
      default: v = {$urandom(), $urandom(), $urandom(), $urandom()};
    endcase
    return v;
  endfunction

  function automatic logic [255:0] random_key();
    logic [255:0] k;
    k = '0;
    for (int j = 0; j < 8; j++) k = {k[223:0], $urandom()};
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic check_cipher(input aes_pkg::aes_out_t got);
    aes_pkg::aes_out_t want;
    if (pending_ciphers.size() == 0) begin
      report_mismatch("unexpected ciphertext beat", got.cipher_first, 64'h0);
    end else begin
      want = pending_ciphers.pop_front();
      if (got.cipher_first !== want.cipher_first)
        report_mismatch("cipher_first", got.cipher_first, want.cipher_first);
      if (got.cipher_second !== want.cipher_second)
        report_mismatch("cipher_second", got.cipher_second, want.cipher_second);
    end
  endtask

  task automatic wait_drained();
    while (pending_ciphers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input aes_pkg::cfg_idx_t idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    key_reg[idx] = v;
    rebuild_schedule();
    @(posedge clk);
  endtask

  // Key registers are only touched with no block in flight.
  task automatic load_key(input logic [255:0] k);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(aes_pkg::CFG_KEY_0, k[255:192]);
    write_reg(aes_pkg::CFG_KEY_1, k[191:128]);
    write_reg(aes_pkg::CFG_KEY_2, k[127:64]);
    write_reg(aes_pkg::CFG_KEY_3, k[63:0]);
    cfg_we <= 1'b0;
    loaded_key = k;
  endtask

  // Leaves in_valid high after the accepting edge so back-to-back beats need no gap.
  task automatic send_block(input aes_pkg::aes_in_t blk, input aes_pkg::aes_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_ciphers.push_back(want);
  endtask

  // Result side: random stalls plus a long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_cipher(out_data);
    end
  end

  initial begin
    forever begin
      wait (hold_req);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
      hold_req = 1'b0;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    aes_pkg::aes_in_t  blk;
    aes_pkg::aes_out_t want;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= aes_pkg::CFG_KEY_0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    build_sub_table();
    for (int j = 0; j < 4; j++) key_reg[j] = '0;
    rebuild_schedule();
    loaded_key = KEY_ZERO;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].key != loaded_key) load_key(DIRECTED[i].key);
      want = (DIRECTED[i].known && KAT_BUILD) ? DIRECTED[i].cipher
                                              : encrypt_block(DIRECTED[i].plain);
      send_block(DIRECTED[i].plain, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        1: load_key(KEY_ZERO);
        5: load_key(KEY_ONES);
        default: load_key(random_key());
      endcase
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (ph % 4 == 0 && n == 10) hold_req = 1'b1;
        if (ph % 4 == 3 && n == 50) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        blk = random_block();
        send_block(blk, encrypt_block(blk));
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_ciphers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
